// ----- rtl/bcs_pkg.sv -----
// ----------------------------------------------------------------------------
// bcs_pkg
// Types and constants shared by the bad-character substring search block.
// ----------------------------------------------------------------------------
package bcs_pkg;

    // default store depths
    localparam int MAX_PATTERN_DEF = 64;
    localparam int MAX_TEXT_DEF    = 256;

    // byte alphabet and field widths
    localparam int ALPHABET = 256;
    localparam int CHAR_W   = 8;
    localparam int POS_W    = 8;

    // item kind
    typedef enum logic {
        OP_PATTERN = 1'b0,
        OP_TEXT    = 1'b1
    } opcode_t;

    // search sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_COMPARE,
        ST_LOOKUP,
        ST_SHIFT,
        ST_FINISH
    } state_t;

endpackage

// ----- rtl/bcs_item_if.sv -----
// ----------------------------------------------------------------------------
// bcs_item_if
// Input channel: one pattern or text byte per transfer.
// ----------------------------------------------------------------------------
interface bcs_item_if;

    logic                          valid;
    logic                          ready;
    bcs_pkg::opcode_t              opcode;
    logic [bcs_pkg::CHAR_W-1:0]    char_byte;
    logic                          last_byte;

    modport source (
        output valid,
        output opcode,
        output char_byte,
        output last_byte,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  char_byte,
        input  last_byte,
        output ready
    );

endinterface

// ----- rtl/bcs_result_if.sv -----
// ----------------------------------------------------------------------------
// bcs_result_if
// Result channel: one search outcome per transfer.
// ----------------------------------------------------------------------------
interface bcs_result_if;

    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [bcs_pkg::POS_W-1:0]     match_position;
    logic                          overflow;

    modport source (
        output valid,
        output found,
        output match_position,
        output overflow,
        input  ready
    );

    modport sink (
        input  valid,
        input  found,
        input  match_position,
        input  overflow,
        output ready
    );

endinterface

// ----- rtl/bad_character_substring_search.sv -----
// ----------------------------------------------------------------------------
// bad_character_substring_search
// Boyer-Moore search with the bad-character shift only. Pattern and text
// bytes are loaded into block memories; the last text byte starts a search
// that walks the stored text and reports the leftmost match.
// ----------------------------------------------------------------------------
//
// channel   dir   payload                              transfer
// item      in    opcode, char_byte, last_byte         valid & ready
// result    out   found, match_position, overflow      valid & ready
//
// bytes load at one per cycle while the sequencer is idle.
// after the last text byte the search checks each alignment, does a
// memory read then a compare for each byte compared, and on a mismatch
// a last-occurrence table read then a shift, and at the end hands the
// result to the output register; the memories are read through registers.
// the occurrence table has one valid flop per byte value, cleared at reset
// and at each new pattern, so there is no clearing pass.
// the output register holds a result until it is taken; loading resumes
// as soon as the result has been moved to it.
// ----------------------------------------------------------------------------
module bad_character_substring_search #(
    parameter int MAX_PATTERN = bcs_pkg::MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = bcs_pkg::MAX_TEXT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    bcs_item_if.sink            item,
    bcs_result_if.source        result
);

    // widths
    localparam int PAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PLW = $clog2(MAX_PATTERN + 1);
    localparam int TAW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int TLW = $clog2(MAX_TEXT + 1);
    localparam int SW  = ((TLW > PAW + 1) ? TLW : PAW + 1) + 1;

    // memories
    logic [bcs_pkg::CHAR_W-1:0] pat_mem [MAX_PATTERN];
    logic [bcs_pkg::CHAR_W-1:0] txt_mem [MAX_TEXT];
    logic [PAW-1:0]             occ_mem [bcs_pkg::ALPHABET];

    // control registers
    bcs_pkg::state_t            state_reg, state_next;
    logic [PLW-1:0]             pat_len_reg, pat_len_next;
    logic                       pat_over_reg, pat_over_next;
    logic                       pat_open_reg, pat_open_next;
    logic [TLW-1:0]             txt_len_reg, txt_len_next;
    logic                       txt_over_reg, txt_over_next;
    logic                       txt_open_reg, txt_open_next;
    logic [bcs_pkg::ALPHABET-1:0] occ_valid_reg, occ_valid_next;
    logic [TLW-1:0]             s_reg, s_next;
    logic [PAW-1:0]             j_reg, j_next;
    logic                       out_valid_reg, out_valid_next;

    // result and read data registers
    logic                       res_found_reg, res_found_next;
    logic [bcs_pkg::POS_W-1:0]  res_pos_reg, res_pos_next;
    logic                       res_ovf_reg, res_ovf_next;
    logic                       out_found_reg, out_found_next;
    logic [bcs_pkg::POS_W-1:0]  out_pos_reg, out_pos_next;
    logic                       out_ovf_reg, out_ovf_next;
    logic [bcs_pkg::CHAR_W-1:0] pat_rdata_reg;
    logic [bcs_pkg::CHAR_W-1:0] txt_rdata_reg;
    logic [PAW-1:0]             occ_rdata_reg;
    logic                       occ_hit_reg;

    // combinational helpers
    logic                       item_xfer;
    logic                       is_text;
    logic [PLW-1:0]             pat_base;
    logic [TLW-1:0]             txt_base;
    logic                       pat_we;
    logic                       txt_we;
    logic [TAW-1:0]             txt_raddr;
    logic                       fits;
    logic                       chars_eq;
    logic                       out_free;
    logic [PAW:0]               shift;
    logic [SW-1:0]              s_sum;

    assign item_xfer = item.valid && item.ready;
    assign is_text   = (item.opcode == bcs_pkg::OP_TEXT);
    assign pat_base  = pat_open_reg ? pat_len_reg : '0;
    assign txt_base  = txt_open_reg ? txt_len_reg : '0;
    assign pat_we    = item_xfer && !is_text && (32'(pat_base) < MAX_PATTERN);
    assign txt_we    = item_xfer && is_text && (32'(txt_base) < MAX_TEXT);
    assign txt_raddr = TAW'(SW'(s_reg) + SW'(j_reg));
    assign fits      = (SW'(s_reg) + SW'(pat_len_reg)) <= SW'(txt_len_reg);
    assign chars_eq  = (pat_rdata_reg == txt_rdata_reg);
    assign out_free  = !out_valid_reg || result.ready;

    // bad-character shift, at least one
    always_comb
    begin
        if (occ_hit_reg && (occ_rdata_reg < j_reg))
            shift = (PAW + 1)'(j_reg - occ_rdata_reg);
        else if (occ_hit_reg)
            shift = (PAW + 1)'(1);
        else
            shift = (PAW + 1)'(j_reg) + (PAW + 1)'(1);
    end
    assign s_sum = SW'(s_reg) + SW'(shift);

    // memory writes and registered reads
    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_mem[pat_base[PAW-1:0]] <= item.char_byte;
            occ_mem[item.char_byte]    <= PAW'(pat_base);
        end
        if (txt_we)
            txt_mem[txt_base[TAW-1:0]] <= item.char_byte;
        pat_rdata_reg <= pat_mem[j_reg];
        txt_rdata_reg <= txt_mem[txt_raddr];
        occ_rdata_reg <= occ_mem[txt_rdata_reg];
        occ_hit_reg   <= occ_valid_reg[txt_rdata_reg];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bcs_pkg::ST_IDLE:
            begin
                if (item_xfer && is_text && item.last_byte)
                    state_next = bcs_pkg::ST_CHECK;
            end
            bcs_pkg::ST_CHECK:
            begin
                if (txt_over_reg || pat_over_reg || !fits || (pat_len_reg == '0))
                    state_next = bcs_pkg::ST_FINISH;
                else
                    state_next = bcs_pkg::ST_READ;
            end
            bcs_pkg::ST_READ:
                state_next = bcs_pkg::ST_COMPARE;
            bcs_pkg::ST_COMPARE:
            begin
                if (!chars_eq)
                    state_next = bcs_pkg::ST_LOOKUP;
                else if (j_reg == '0)
                    state_next = bcs_pkg::ST_FINISH;
                else
                    state_next = bcs_pkg::ST_READ;
            end
            bcs_pkg::ST_LOOKUP:
                state_next = bcs_pkg::ST_SHIFT;
            bcs_pkg::ST_SHIFT:
                state_next = bcs_pkg::ST_CHECK;
            bcs_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = bcs_pkg::ST_IDLE;
            end
            default:
                state_next = bcs_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pat_len_next   = pat_len_reg;
        pat_over_next  = pat_over_reg;
        pat_open_next  = pat_open_reg;
        txt_len_next   = txt_len_reg;
        txt_over_next  = txt_over_reg;
        txt_open_next  = txt_open_reg;
        occ_valid_next = occ_valid_reg;
        s_next         = s_reg;
        j_next         = j_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        res_ovf_next   = res_ovf_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;
        out_ovf_next   = out_ovf_reg;

        if (result.valid && result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            bcs_pkg::ST_IDLE:
            begin
                // pattern byte transfer
                if (item_xfer && !is_text)
                begin
                    txt_open_next = 1'b0;
                    if (!pat_open_reg)
                    begin
                        pat_over_next  = 1'b0;
                        occ_valid_next = '0;
                    end
                    if (pat_we)
                    begin
                        pat_len_next = pat_base + PLW'(1);
                        occ_valid_next[item.char_byte] = 1'b1;
                    end
                    else
                    begin
                        pat_len_next  = pat_base;
                        pat_over_next = 1'b1;
                    end
                    pat_open_next = !item.last_byte;
                end
                // text byte transfer
                if (item_xfer && is_text)
                begin
                    pat_open_next = 1'b0;
                    if (!txt_open_reg)
                        txt_over_next = 1'b0;
                    if (txt_we)
                        txt_len_next = txt_base + TLW'(1);
                    else
                    begin
                        txt_len_next  = txt_base;
                        txt_over_next = 1'b1;
                    end
                    txt_open_next = !item.last_byte;
                    s_next        = '0;
                end
            end
            bcs_pkg::ST_CHECK:
            begin
                res_found_next = 1'b0;
                res_pos_next   = '0;
                res_ovf_next   = txt_over_reg || pat_over_reg;
                if (!(txt_over_reg || pat_over_reg) && fits && (pat_len_reg == '0))
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = bcs_pkg::POS_W'(s_reg);
                end
                j_next = PAW'(pat_len_reg - PLW'(1));
            end
            bcs_pkg::ST_COMPARE:
            begin
                if (chars_eq && (j_reg == '0))
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = bcs_pkg::POS_W'(s_reg);
                end
                else if (chars_eq)
                    j_next = j_reg - PAW'(1);
            end
            bcs_pkg::ST_SHIFT:
                s_next = TLW'(s_sum);
            bcs_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_pos_next   = res_pos_reg;
                    out_ovf_next   = res_ovf_reg;
                end
            end
            default:
            begin
                s_next = s_reg;
            end
        endcase
    end

    assign item.ready            = (state_reg == bcs_pkg::ST_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.found          = out_found_reg;
    assign result.match_position = out_pos_reg;
    assign result.overflow       = out_ovf_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bcs_pkg::ST_IDLE;
            pat_len_reg   <= '0;
            pat_over_reg  <= 1'b0;
            pat_open_reg  <= 1'b0;
            txt_len_reg   <= '0;
            txt_over_reg  <= 1'b0;
            txt_open_reg  <= 1'b0;
            occ_valid_reg <= '0;
            s_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pat_len_reg   <= pat_len_next;
            pat_over_reg  <= pat_over_next;
            pat_open_reg  <= pat_open_next;
            txt_len_reg   <= txt_len_next;
            txt_over_reg  <= txt_over_next;
            txt_open_reg  <= txt_open_next;
            occ_valid_reg <= occ_valid_next;
            s_reg         <= s_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        res_ovf_reg   <= res_ovf_next;
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
        out_ovf_reg   <= out_ovf_next;
    end

endmodule
